### rtl/core/rvx_pkg.sv
// Shared constants, opcodes and inter-module structs for the rv32 subset execute unit.
`default_nettype none

package rvx_pkg;

	localparam int unsigned XLEN         = 32;
	localparam int unsigned RIDX_W       = 5;
	localparam int unsigned IMM_W        = 12;
	localparam int unsigned NUM_REGS_DEF = 32;
	// data memory depth, power of two: word slot is a plain slice of the address
	localparam int unsigned MEM_WORDS    = 1024;
	localparam int unsigned MEM_AW       = $clog2(MEM_WORDS);

	typedef enum logic [2:0] {
		OP_LW   = 3'd0,
		OP_SW   = 3'd1,
		OP_ADD  = 3'd2,
		OP_ADDI = 3'd3,
		OP_AND  = 3'd4,
		OP_OR   = 3'd5,
		OP_XOR  = 3'd6,
		OP_BAD  = 3'd7
	} op_t;

	typedef struct packed {
		logic              en;
		logic [RIDX_W-1:0] idx;
		logic [XLEN-1:0]   data;
	} rf_wr_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [MEM_AW-1:0] addr;
		logic [XLEN-1:0]   wdata;
	} dm_req_t;

endpackage

`default_nettype wire

### rtl/core/rv32_subset_execute_unit_core.sv
// Top level of the rv32 subset execute unit: two-stage pipeline around register file and data memory.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one decoded instruction per beat:
//   mode, dest_index, src_a_index, src_b_index, immediate.
//   Output channel (out_valid/out_ready) gives one result beat per instruction,
//   in order: reg_written, written_index, written_value, data_address,
//   bad_instruction.
//   Path: an accepted beat is registered into stage 1, then into the stage-2 output register.
//   Throughput: 1 instruction per cycle unless in_ready is held low; register reads are
//   issued at accept, execute and memory access happen in stage 1, load data and register
//   write-back in stage 2. Dependences on in-flight results are forwarded.
//   Reset: register file reads back entry i as i until written. The data
//   memory is zeroed by a sweep over all MEM_WORDS (1024) words after reset;
//   in_ready stays low during the sweep.
//   Stall: with out_ready low, one more instruction is taken into stage 1,
//   then in_ready drops until the output beat is taken. Register writes
//   commit when the output beat is taken; stores are written as they leave
//   stage 1.
`default_nettype none

module rv32_subset_execute_unit_core #(
	parameter int unsigned NUM_REGS = rvx_pkg::NUM_REGS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic        [2:0]                mode,
	input  wire logic        [rvx_pkg::RIDX_W-1:0] dest_index,
	input  wire logic        [rvx_pkg::RIDX_W-1:0] src_a_index,
	input  wire logic        [rvx_pkg::RIDX_W-1:0] src_b_index,
	input  wire logic signed [rvx_pkg::IMM_W-1:0] immediate,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  reg_written,
	output logic             [rvx_pkg::RIDX_W-1:0] written_index,
	output logic signed      [rvx_pkg::XLEN-1:0]  written_value,
	output logic             [rvx_pkg::XLEN-1:0]  data_address,
	output logic                                  bad_instruction
);

	localparam int unsigned XL = rvx_pkg::XLEN;
	localparam int unsigned RW = rvx_pkg::RIDX_W;
	localparam int unsigned IW = rvx_pkg::IMM_W;

	logic                 busy;
	logic                 in_acc, out_acc, adv, s1_go;
	rvx_pkg::op_t         in_op;
	logic [RW-1:0]        rd_a_sel;
	logic [XL-1:0]        rf_a, rf_b;
	rvx_pkg::rf_wr_t      rf_wr;
	rvx_pkg::dm_req_t     dm_req;
	logic [XL-1:0]        dm_rdata;

	logic                 v_s1;
	rvx_pkg::op_t         op_s1;
	logic [RW-1:0]        rd_s1, ra_s1, rb_s1;
	logic [IW-1:0]        imm_s1;

	logic                 v_s2, lw_s2, wr_s2, bad_s2;
	logic [RW-1:0]        idx_s2;
	logic [XL-1:0]        alu_s2, addr_s2, val_s2;

	logic                 last_en_q;
	logic [RW-1:0]        last_idx_q;
	logic [XL-1:0]        last_val_q;

	logic [RW-1:0]        a_idx_s1;
	logic [XL-1:0]        a_val, b_val, imm_ext, ea, alu_val;
	logic                 is_mem, does_wr, wr_ok;

	assign in_op    = rvx_pkg::op_t'(mode);
	assign adv      = !v_s2 || out_ready;
	assign s1_go    = v_s1 && adv;
	assign in_ready = !busy && (!v_s1 || adv);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = v_s2 && out_ready;
	assign rd_a_sel = (in_op == rvx_pkg::OP_SW) ? dest_index : src_a_index;

	rvx_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_a_idx (rd_a_sel),
		.rd_b_idx (src_b_index),
		.rd_a_data(rf_a),
		.rd_b_data(rf_b),
		.wr       (rf_wr)
	);

	rvx_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rd_data(dm_rdata),
		.busy   (busy)
	);

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= in_op;
			rd_s1  <= dest_index;
			ra_s1  <= src_a_index;
			rb_s1  <= src_b_index;
			imm_s1 <= immediate;
		end
	end

	// forwarding: pending stage-2 result first, then the last committed write
	assign a_idx_s1 = (op_s1 == rvx_pkg::OP_SW) ? rd_s1 : ra_s1;

	always_comb begin
		if (v_s2 && wr_s2 && idx_s2 == a_idx_s1) begin
			a_val = val_s2;
		end else if (last_en_q && last_idx_q == a_idx_s1) begin
			a_val = last_val_q;
		end else begin
			a_val = rf_a;
		end
		if (v_s2 && wr_s2 && idx_s2 == rb_s1) begin
			b_val = val_s2;
		end else if (last_en_q && last_idx_q == rb_s1) begin
			b_val = last_val_q;
		end else begin
			b_val = rf_b;
		end
	end

	assign imm_ext = {{(XL - IW){imm_s1[IW-1]}}, imm_s1};
	assign ea      = b_val + imm_ext;
	assign is_mem  = op_s1 inside {rvx_pkg::OP_LW, rvx_pkg::OP_SW};
	assign does_wr = op_s1 inside {rvx_pkg::OP_LW, rvx_pkg::OP_ADD, rvx_pkg::OP_ADDI,
		rvx_pkg::OP_AND, rvx_pkg::OP_OR, rvx_pkg::OP_XOR};
	assign wr_ok   = does_wr && (rd_s1 < NUM_REGS);

	always_comb begin
		case (op_s1)
			rvx_pkg::OP_ADD:  alu_val = a_val + b_val;
			rvx_pkg::OP_ADDI: alu_val = a_val + imm_ext;
			rvx_pkg::OP_AND:  alu_val = a_val & b_val;
			rvx_pkg::OP_OR:   alu_val = a_val | b_val;
			rvx_pkg::OP_XOR:  alu_val = a_val ^ b_val;
			default:          alu_val = '0;
		endcase
	end

	always_comb begin
		dm_req.rd_en = s1_go && (op_s1 == rvx_pkg::OP_LW);
		dm_req.wr_en = s1_go && (op_s1 == rvx_pkg::OP_SW);
		dm_req.addr  = ea[rvx_pkg::MEM_AW+1:2];
		dm_req.wdata = a_val;
	end

	// stage 2 / output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			lw_s2   <= op_s1 == rvx_pkg::OP_LW;
			wr_s2   <= wr_ok;
			idx_s2  <= wr_ok ? rd_s1 : '0;
			alu_s2  <= alu_val;
			addr_s2 <= is_mem ? ea : '0;
			bad_s2  <= op_s1 == rvx_pkg::OP_BAD;
		end
	end

	assign val_s2 = lw_s2 ? dm_rdata : alu_s2;

	always_comb begin
		rf_wr.en   = out_acc && wr_s2;
		rf_wr.idx  = idx_s2;
		rf_wr.data = val_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_en_q <= 1'b0;
		end else if (rf_wr.en) begin
			last_en_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_wr.en) begin
			last_idx_q <= idx_s2;
			last_val_q <= val_s2;
		end
	end

	assign out_valid       = v_s2;
	assign reg_written     = wr_s2;
	assign written_index   = idx_s2;
	assign written_value   = wr_s2 ? val_s2 : '0;
	assign data_address    = addr_s2;
	assign bad_instruction = bad_s2;

endmodule

`default_nettype wire

### rtl/core/rvx_regfile.sv
// Register file: two registered read ports, one write port, per-entry valid bits for reset values.
`default_nettype none

module rvx_regfile #(
	parameter int unsigned NUM_REGS = rvx_pkg::NUM_REGS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rd_en,
	input  wire logic [rvx_pkg::RIDX_W-1:0] rd_a_idx,
	input  wire logic [rvx_pkg::RIDX_W-1:0] rd_b_idx,
	output logic      [rvx_pkg::XLEN-1:0]   rd_a_data,
	output logic      [rvx_pkg::XLEN-1:0]   rd_b_data,
	input  wire rvx_pkg::rf_wr_t            wr
);

	localparam int unsigned DEPTH = (NUM_REGS > (1 << rvx_pkg::RIDX_W)) ?
		(1 << rvx_pkg::RIDX_W) : NUM_REGS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PAD_W = rvx_pkg::XLEN - rvx_pkg::RIDX_W;

	logic [rvx_pkg::XLEN-1:0]   mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;

	logic                       a_inr, b_inr, w_inr;
	logic [AW-1:0]              a_addr, b_addr, w_addr;

	logic [rvx_pkg::XLEN-1:0]   a_mem_q, b_mem_q;
	logic                       a_vld_q, b_vld_q, a_inr_q, b_inr_q;
	logic [rvx_pkg::RIDX_W-1:0] a_idx_q, b_idx_q;

	assign a_inr  = rd_a_idx < NUM_REGS;
	assign b_inr  = rd_b_idx < NUM_REGS;
	assign w_inr  = wr.idx < NUM_REGS;
	assign a_addr = a_inr ? rd_a_idx[AW-1:0] : '0;
	assign b_addr = b_inr ? rd_b_idx[AW-1:0] : '0;
	assign w_addr = w_inr ? wr.idx[AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en && w_inr) begin
			vld_q[w_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && w_inr) begin
			mem[w_addr] <= wr.data;
		end
		if (rd_en) begin
			a_mem_q <= mem[a_addr];
			b_mem_q <= mem[b_addr];
			a_vld_q <= vld_q[a_addr];
			b_vld_q <= vld_q[b_addr];
			a_inr_q <= a_inr;
			b_inr_q <= b_inr;
			a_idx_q <= rd_a_idx;
			b_idx_q <= rd_b_idx;
		end
	end

	// unwritten entry reads as its own index
	assign rd_a_data = !a_inr_q ? '0 : (a_vld_q ? a_mem_q : {{PAD_W{1'b0}}, a_idx_q});
	assign rd_b_data = !b_inr_q ? '0 : (b_vld_q ? b_mem_q : {{PAD_W{1'b0}}, b_idx_q});

endmodule

`default_nettype wire

### rtl/core/rvx_dmem.sv
// Word data memory with registered read and a zeroing sweep after reset.
`default_nettype none

module rvx_dmem (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rvx_pkg::dm_req_t         req,
	output logic      [rvx_pkg::XLEN-1:0] rd_data,
	output logic                          busy
);

	localparam logic [rvx_pkg::MEM_AW:0] CLR_END = (rvx_pkg::MEM_AW + 1)'(rvx_pkg::MEM_WORDS);

	logic [rvx_pkg::XLEN-1:0]   mem [rvx_pkg::MEM_WORDS];
	logic [rvx_pkg::MEM_AW:0]   clr_cnt_q;
	logic [rvx_pkg::XLEN-1:0]   rdata_q;

	assign busy    = clr_cnt_q != CLR_END;
	assign rd_data = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_cnt_q[rvx_pkg::MEM_AW-1:0]] <= '0;
		end else if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/rvx_checker.sv
// Port-level assertions for the execute unit, bound to the top level.
`default_nettype none

module rvx_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        reg_written,
	input wire logic [rvx_pkg::RIDX_W-1:0]  written_index,
	input wire logic [rvx_pkg::XLEN-1:0]    written_value,
	input wire logic [rvx_pkg::XLEN-1:0]    data_address,
	input wire logic                        bad_instruction
);

	a_bad_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_instruction |-> !reg_written && data_address == '0)
		else $error("bad instruction beat shows a register write or address");

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_written |-> written_index == '0 && written_value == '0)
		else $error("beat without register write carries nonzero index or value");

	a_write_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> !bad_instruction)
		else $error("beat flags both a register write and a bad instruction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(written_value)
			&& $stable(data_address))
		else $error("stalled output beat dropped or changed");

endmodule

bind rv32_subset_execute_unit_core rvx_checker u_rvx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.reg_written    (reg_written),
	.written_index  (written_index),
	.written_value  (written_value),
	.data_address   (data_address),
	.bad_instruction(bad_instruction)
);

`default_nettype wire
